// ----- src/modexp_pkg.sv -----
`default_nettype none

package modexp_pkg;

   // Width of every field on the channels.
   localparam int FIELD_W = 32;

   // Default operand width inside the datapath.
   localparam int OPERAND_W = 32;

   // Smallest modulus that reduces; anything below gives a zero result.
   localparam int MIN_MODULUS = 2;

   // Sequencer states.
   localparam int STATE_W = 3;

endpackage

`default_nettype wire

// ----- src/modexp_if.sv -----
`default_nettype none

interface modexp_req_if import modexp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] base_value;
   logic [FIELD_W-1:0] exponent;
   logic [FIELD_W-1:0] modulus;

   modport source (output valid, output base_value, output exponent, output modulus,
                   input ready);
   modport sink   (input valid, input base_value, input exponent, input modulus,
                   output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] power_result;

   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

`default_nettype wire

// ----- src/modexp_mulmod.sv -----
`default_nettype none

// Bit-serial modular multiplier: product = (a * b) mod m, for a, b < m.
// The multiplier b is scanned from its top bit, one bit per cycle, with a
// modular double followed by a conditional modular add.
module modexp_mulmod import modexp_pkg::*; #(
   parameter int WIDTH = OPERAND_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic [WIDTH-1:0] op_m,
   output logic                  done,
   output logic      [WIDTH-1:0] product
);

   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] mplr_ff, mplr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   dbl_sum;
   logic [WIDTH:0]   add_sum;
   logic [WIDTH-1:0] dbl_mod;
   logic [WIDTH-1:0] add_mod;
   logic [WIDTH-1:0] step_acc;

   // One step: acc = 2*acc mod m, then + a mod m when the current bit is set.
   always_comb begin
      dbl_sum  = {acc_ff, 1'b0};
      dbl_mod  = (dbl_sum >= {1'b0, m_ff}) ? WIDTH'(dbl_sum - {1'b0, m_ff})
                                           : dbl_sum[WIDTH-1:0];
      add_sum  = {1'b0, dbl_mod} + {1'b0, a_ff};
      add_mod  = (add_sum >= {1'b0, m_ff}) ? WIDTH'(add_sum - {1'b0, m_ff})
                                           : add_sum[WIDTH-1:0];
      step_acc = mplr_ff[WIDTH-1] ? add_mod : dbl_mod;
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      mplr_in = mplr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         m_in    = op_m;
         mplr_in = op_b;
         cnt_in  = CNT_W'(WIDTH - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         acc_in  = step_acc;
         mplr_in = {mplr_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      m_ff    <= m_in;
      mplr_ff <= mplr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ----- src/modular_exponentiation.sv -----
// Modular exponentiation: each request beat carries base_value, exponent and
// modulus; one response beat returns base_value ** exponent mod modulus.
// Operands are taken at WIDTH bits (the 32-bit fields are zero-extended or
// cut to WIDTH), and the low 32 bits of the result are returned. A modulus
// below two gives zero. The work is right-to-left square and multiply on a
// single bit-serial modular multiplier that handles one multiplier bit per
// cycle. An item first reduces the base (one product), then for every
// exponent bit up to the highest set one runs a squaring plus, for a set
// bit, a multiply. A zero exponent finishes after the base reduction, and
// a modulus below two right away. One item is in flight at a time; a new
// request is taken once the finished result sits in the output register,
// even while that beat still waits for rsp ready.
`default_nettype none

module modular_exponentiation import modexp_pkg::*; #(
   parameter int WIDTH = OPERAND_W
) (
   input  wire logic     clock,
   input  wire logic     reset,
   modexp_req_if.sink    req_bus,
   modexp_rsp_if.source  rsp_bus
);

   // Sequencer states
   localparam logic [STATE_W-1:0] ST_IDLE   = STATE_W'(0);
   localparam logic [STATE_W-1:0] ST_REDUCE = STATE_W'(1);   // base mod m
   localparam logic [STATE_W-1:0] ST_MULR   = STATE_W'(2);   // r = r * b mod m
   localparam logic [STATE_W-1:0] ST_SQR    = STATE_W'(3);   // b = b * b mod m
   localparam logic [STATE_W-1:0] ST_FINISH = STATE_W'(4);   // hand r to output reg

   logic [STATE_W-1:0] state_ff, state_in;
   logic [WIDTH-1:0]   e_ff, e_in;      // exponent, shifted right per bit
   logic [WIDTH-1:0]   r_ff, r_in;      // running result
   logic [WIDTH-1:0]   b_ff, b_in;      // running base power
   logic [WIDTH-1:0]   m_ff, m_in;      // modulus
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   // Request operands at datapath width
   logic [WIDTH-1:0]   in_base;
   logic [WIDTH-1:0]   in_exp;
   logic [WIDTH-1:0]   in_mod;

   // Multiplier hookup
   logic               mm_start;
   logic [WIDTH-1:0]   mm_a;
   logic [WIDTH-1:0]   mm_b;
   logic [WIDTH-1:0]   mm_m;
   logic               mm_done;
   logic [WIDTH-1:0]   mm_product;

   // Next exponent step
   logic               chain;
   logic [WIDTH-1:0]   nxt_e;
   logic [WIDTH-1:0]   nxt_b;

   assign in_base = WIDTH'(req_bus.base_value);
   assign in_exp  = WIDTH'(req_bus.exponent);
   assign in_mod  = WIDTH'(req_bus.modulus);

   assign req_bus.ready = (state_ff == ST_IDLE);

   modexp_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .op_m    (mm_m),
      .done    (mm_done),
      .product (mm_product)
   );

   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      m_in     = m_ff;
      mm_start = 1'b0;
      mm_a     = b_ff;
      mm_b     = b_ff;
      mm_m     = m_ff;
      chain    = 1'b0;
      nxt_e    = e_ff;
      nxt_b    = b_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               e_in = in_exp;
               m_in = in_mod;
               if (in_mod < WIDTH'(MIN_MODULUS)) begin
                  // nothing to reduce into: result is zero
                  r_in     = '0;
                  state_in = ST_FINISH;
               end else begin
                  // base mod m computed as (1 * base) mod m on the multiplier
                  r_in     = WIDTH'(1);
                  mm_start = 1'b1;
                  mm_a     = WIDTH'(1);
                  mm_b     = in_base;
                  mm_m     = in_mod;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mm_done) begin
               b_in  = mm_product;
               nxt_b = mm_product;
               chain = 1'b1;
            end
         end
         ST_MULR: begin
            if (mm_done) begin
               r_in     = mm_product;
               mm_start = 1'b1;
               mm_a     = b_ff;
               mm_b     = b_ff;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mm_done) begin
               b_in  = mm_product;
               nxt_b = mm_product;
               nxt_e = e_ff >> 1;
               e_in  = nxt_e;
               chain = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Pick the work for the next exponent bit; stop once no set bit remains.
      if (chain) begin
         priority if (nxt_e == '0) begin
            state_in = ST_FINISH;
         end else if (nxt_e[0]) begin
            mm_start = 1'b1;
            mm_a     = r_ff;
            mm_b     = nxt_b;
            state_in = ST_MULR;
         end else begin
            mm_start = 1'b1;
            mm_a     = nxt_b;
            mm_b     = nxt_b;
            state_in = ST_SQR;
         end
      end
   end

   // Output register: holds the beat until taken, loads from FINISH.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = FIELD_W'(r_ff);
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      r_ff        <= r_in;
      b_ff        <= b_in;
      m_ff        <= m_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.power_result = rsp_data_ff;

endmodule

`default_nettype wire
